// ===== design/cmr_pkg.sv =====
// Shared types and constants of the CAN multi-frame reassembly pool.
package cmr_pkg;

  typedef logic [7:0] slot_idx_t;

  localparam slot_idx_t SLOT_END = 8'hFF;
  localparam logic [3:0] SINGLE_EMPTY = 4'hF;
  localparam logic [5:0] READ_WORDS = 6'd32;

  typedef enum logic [1:0] {
    FT_SEQ    = 2'd0,
    FT_START  = 2'd1,
    FT_END    = 2'd2,
    FT_SINGLE = 2'd3
  } frame_type_t;

  typedef enum logic [3:0] {
    ST_ACCEPT  = 4'd0,
    ST_DROP    = 4'd1,
    ST_READY   = 4'd2,
    ST_BADLEN  = 4'd3,
    ST_SLOTS   = 4'd4,
    ST_STREAMS = 4'd5,
    ST_ORPHAN  = 4'd6,
    ST_LONG    = 4'd7,
    ST_DATA    = 4'd8,
    ST_NONE    = 4'd9
  } status_t;

  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    slot_idx_t next;
    logic      pay_en;
  } slot_wr_t;

  typedef struct packed {
    logic      en;
    slot_idx_t addr;
  } slot_rd_t;

  typedef struct packed {
    status_t      status;
    logic [7:0]   src;
    logic [15:0]  pid;
    logic [63:0]  data;
    logic [3:0]   nb;
    logic [9:0]   pos;
    logic         last;
  } res_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] nb);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = (4'(b) < nb) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== design/cmr_if.sv =====
// Channel interfaces: input items and result items.
interface cmr_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  frame_type;
  logic [3:0]  seq_number;
  logic [7:0]  source_id;
  logic [15:0] packet_id;
  logic [63:0] frame_data;
  logic [3:0]  frame_length;
  logic [9:0]  buffer_bytes;

  modport source(output valid, kind, frame_type, seq_number, source_id, packet_id,
                 frame_data, frame_length, buffer_bytes, input ready);
  modport sink(input valid, kind, frame_type, seq_number, source_id, packet_id,
               frame_data, frame_length, buffer_bytes, output ready);
endinterface

interface cmr_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  source_out;
  logic [15:0] packet_out;
  logic [63:0] data_word;
  logic [3:0]  word_bytes;
  logic [9:0]  total_bytes;
  logic        last;

  modport source(output valid, status, source_out, packet_out, data_word, word_bytes,
                 total_bytes, last, input ready);
  modport sink(input valid, status, source_out, packet_out, data_word, word_bytes,
               total_bytes, last, output ready);
endinterface

// ===== design/can_multiframe_reassembly_pool_core.sv =====
// Top level: CAN multi-frame reassembly over a linked slot pool.
// After reset a clearing pass links the free list, with ready low.
// Push: stream scan steps, a read and a write per freed slot, a read and a check per
// chain link walked on append, and a read and a write to take a slot.
// Read: a memory read and a check per data word, then a read and a write per
// freed slot; one item is worked on at a time, the next is taken back in idle.
module can_multiframe_reassembly_pool_core #(
  parameter int SLOTS     = 128,
  parameter int STREAMS   = 8,
  parameter int MAX_CHAIN = 32,
  parameter int SEQ_MAX   = 15,
  parameter int AGE_LIMIT = 7
) (
  input  logic          clk,
  input  logic          rst,
  cmr_item_if.sink      item,
  cmr_result_if.source  result
);
  localparam int SW  = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int SCW = $clog2(STREAMS + 1);
  localparam int NW  = $clog2(MAX_CHAIN + 1);
  localparam cmr_pkg::slot_idx_t SLOT_LIM = cmr_pkg::slot_idx_t'(SLOTS);
  localparam logic [3:0] SEQ_TOP = 4'(SEQ_MAX);
  localparam logic [2:0] AGE_TOP = 3'(AGE_LIMIT);
  localparam logic [SCW-1:0] SC_END = SCW'(STREAMS);
  localparam logic [NW-1:0] CHAIN_TOP = NW'(MAX_CHAIN);

  typedef enum logic [16:0] {
    S_INIT   = 17'h00001,
    S_IDLE   = 17'h00002,
    S_EXT    = 17'h00004,
    S_FIND   = 17'h00008,
    S_DROP   = 17'h00010,
    S_AGE    = 17'h00020,
    S_FC_RD  = 17'h00040,
    S_FC_WR  = 17'h00080,
    S_AP_RD  = 17'h00100,
    S_AP_CK  = 17'h00200,
    S_TK_RD  = 17'h00400,
    S_TK_WR  = 17'h00800,
    S_RES    = 17'h01000,
    S_R_SCAN = 17'h02000,
    S_RW_RD  = 17'h04000,
    S_RW_CK  = 17'h08000,
    S_R_FIN  = 17'h10000
  } state_t;

  typedef enum logic [1:0] {
    AD_FIND = 2'd0,
    AD_AGE  = 2'd1,
    AD_RES  = 2'd2
  } after_t;

  state_t state, ret;
  after_t after_drop;
  logic   age_then_drop;

  cmr_pkg::slot_idx_t init_cnt, free_head, cur;
  cmr_pkg::slot_idx_t s_head [STREAMS];
  logic [23:0]        s_key  [STREAMS];
  logic [3:0]         s_exp  [STREAMS];
  logic [3:0]         s_fl   [STREAMS];
  logic [2:0]         s_age  [STREAMS];

  logic [3:0]  r_seq;
  logic [23:0] r_key;
  logic [63:0] r_data;
  logic [9:0]  r_sz;
  logic [3:0]  fl_in;

  cmr_pkg::status_t st;
  logic [SCW-1:0] sc;
  logic [SW-1:0]  sci, cs;
  logic [NW-1:0]  ap_n;
  logic [9:0]     pos;
  logic [5:0]     words;

  cmr_pkg::res_t pend, out_d;
  logic          out_v, out_free, rw_emit, out_load;

  cmr_pkg::slot_wr_t  mem_wr;
  cmr_pkg::slot_rd_t  mem_rd;
  cmr_pkg::slot_idx_t rnext;
  logic [63:0]        rpay;

  logic          u_found, m_found;
  logic [SW-1:0] u_idx, m_idx;
  logic [3:0]    e_exp, e_prev, c_fl;
  logic [10:0]   pos_w, pos_f;

  cmr_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .wpay  (r_data),
    .rd    (mem_rd),
    .rnext (rnext),
    .rpay  (rpay)
  );

  assign sci      = sc[SW-1:0];
  assign out_free = !out_v || result.ready;
  assign e_exp    = s_exp[m_idx];
  assign e_prev   = (e_exp != 4'd0) ? e_exp - 4'd1 : SEQ_TOP;
  assign c_fl     = s_fl[cs];
  assign pos_w    = {1'b0, pos} + 11'd8;
  assign pos_f    = {1'b0, pos} + {7'd0, c_fl};
  assign rw_emit  = (rnext < SLOT_LIM)
                    ? !(pos_w > {1'b0, r_sz} || words >= cmr_pkg::READ_WORDS)
                    : (c_fl <= 4'd8 && pos_f <= {1'b0, r_sz} && words < cmr_pkg::READ_WORDS);
  assign out_load = out_free && ((state == S_RES) || (state == S_R_FIN) ||
                                 (state == S_RW_CK && rw_emit));

  always_comb begin
    u_found = 1'b0;
    u_idx   = '0;
    m_found = 1'b0;
    m_idx   = '0;
    for (int s = STREAMS - 1; s >= 0; s--) begin
      if (s_head[s] >= SLOT_LIM) begin
        u_found = 1'b1;
        u_idx   = SW'(s);
      end
      if (s_head[s] < SLOT_LIM && s_fl[s] == 4'd0 && s_key[s] == r_key) begin
        m_found = 1'b1;
        m_idx   = SW'(s);
      end
    end
  end

  always_comb begin
    mem_wr = '0;
    mem_rd = '0;
    unique case (state)
      S_INIT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = init_cnt;
        mem_wr.next = (init_cnt == SLOT_LIM - 8'd1) ? cmr_pkg::SLOT_END : init_cnt + 8'd1;
      end
      S_FC_RD, S_AP_RD, S_RW_RD: begin
        mem_rd.en   = 1'b1;
        mem_rd.addr = cur;
      end
      S_FC_WR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = cur;
        mem_wr.next = free_head;
      end
      S_AP_CK: begin
        mem_wr.en   = (ap_n != CHAIN_TOP) && (rnext >= SLOT_LIM);
        mem_wr.addr = cur;
        mem_wr.next = free_head;
      end
      S_TK_RD: begin
        mem_rd.en   = 1'b1;
        mem_rd.addr = free_head;
      end
      S_TK_WR: begin
        mem_wr.en     = 1'b1;
        mem_wr.addr   = free_head;
        mem_wr.next   = cmr_pkg::SLOT_END;
        mem_wr.pay_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_load) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      init_cnt      <= '0;
      free_head     <= '0;
      age_then_drop <= 1'b0;
      for (int s = 0; s < STREAMS; s++) begin
        s_head[s] <= cmr_pkg::SLOT_END;
        s_key[s]  <= '0;
        s_exp[s]  <= '0;
        s_fl[s]   <= '0;
        s_age[s]  <= '0;
      end
    end else begin
      unique case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 8'd1;
          if (init_cnt == SLOT_LIM - 8'd1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item.valid) begin
            r_seq         <= item.seq_number;
            r_key         <= {item.source_id, item.packet_id};
            r_data        <= item.frame_data;
            r_sz          <= item.buffer_bytes;
            sc            <= '0;
            age_then_drop <= 1'b0;
            after_drop    <= AD_FIND;
            if (item.kind) begin
              state <= S_R_SCAN;
            end else if (free_head >= SLOT_LIM) begin
              st            <= cmr_pkg::ST_SLOTS;
              age_then_drop <= 1'b1;
              state         <= S_AGE;
            end else begin
              unique case (cmr_pkg::frame_type_t'(item.frame_type))
                cmr_pkg::FT_END: begin
                  fl_in <= item.frame_length;
                  if (item.frame_length == 4'd0) begin
                    st    <= cmr_pkg::ST_BADLEN;
                    state <= S_RES;
                  end else begin
                    state <= S_EXT;
                  end
                end
                cmr_pkg::FT_SINGLE: begin
                  fl_in <= (item.frame_length != 4'd0) ? item.frame_length
                                                       : cmr_pkg::SINGLE_EMPTY;
                  state <= S_DROP;
                end
                cmr_pkg::FT_START: begin
                  fl_in <= 4'd0;
                  if (item.frame_length != 4'd8) begin
                    st    <= cmr_pkg::ST_BADLEN;
                    state <= S_RES;
                  end else begin
                    state <= S_DROP;
                  end
                end
                cmr_pkg::FT_SEQ: begin
                  fl_in <= 4'd0;
                  if (item.frame_length != 4'd8) begin
                    st    <= cmr_pkg::ST_BADLEN;
                    state <= S_RES;
                  end else begin
                    state <= S_EXT;
                  end
                end
                default: state <= S_IDLE;
              endcase
            end
          end
        end
        S_EXT: begin
          sc <= '0;
          if (!m_found) begin
            st    <= cmr_pkg::ST_ORPHAN;
            state <= S_AGE;
          end else begin
            cs <= m_idx;
            if (fl_in == 4'd0 && r_seq != e_exp) begin
              if (r_seq == e_prev) begin
                st    <= cmr_pkg::ST_DROP;
                state <= S_RES;
              end else begin
                st         <= cmr_pkg::ST_ORPHAN;
                after_drop <= AD_AGE;
                state      <= S_DROP;
              end
            end else begin
              cur   <= s_head[m_idx];
              ap_n  <= NW'(1);
              state <= S_AP_RD;
            end
          end
        end
        S_AP_RD: state <= S_AP_CK;
        S_AP_CK: begin
          if (ap_n == CHAIN_TOP) begin
            st         <= cmr_pkg::ST_LONG;
            sc         <= '0;
            after_drop <= AD_AGE;
            state      <= S_DROP;
          end else if (rnext >= SLOT_LIM) begin
            s_age[cs] <= AGE_TOP;
            if (fl_in != 4'd0) begin
              s_fl[cs] <= fl_in;
              st       <= cmr_pkg::ST_READY;
            end else begin
              s_exp[cs] <= (s_exp[cs] >= SEQ_TOP) ? 4'd0 : s_exp[cs] + 4'd1;
              st        <= cmr_pkg::ST_ACCEPT;
            end
            state <= S_TK_RD;
          end else begin
            cur   <= rnext;
            ap_n  <= ap_n + NW'(1);
            state <= S_AP_RD;
          end
        end
        S_FIND: begin
          if (u_found) begin
            s_key[u_idx]  <= r_key;
            s_age[u_idx]  <= AGE_TOP;
            s_fl[u_idx]   <= fl_in;
            s_exp[u_idx]  <= 4'd0;
            s_head[u_idx] <= free_head;
            st            <= (fl_in != 4'd0) ? cmr_pkg::ST_READY : cmr_pkg::ST_ACCEPT;
            state         <= S_TK_RD;
          end else begin
            st    <= cmr_pkg::ST_STREAMS;
            sc    <= '0;
            state <= S_AGE;
          end
        end
        S_TK_RD: state <= S_TK_WR;
        S_TK_WR: begin
          free_head <= rnext;
          state     <= S_RES;
        end
        S_DROP: begin
          if (sc == SC_END) begin
            sc <= '0;
            unique case (after_drop)
              AD_FIND: state <= S_FIND;
              AD_AGE:  state <= S_AGE;
              AD_RES:  state <= S_RES;
              default: state <= S_RES;
            endcase
          end else begin
            sc <= sc + SCW'(1);
            if (s_head[sci] < SLOT_LIM && s_fl[sci] == 4'd0 && s_key[sci] == r_key) begin
              cs    <= sci;
              cur   <= s_head[sci];
              ret   <= S_DROP;
              state <= S_FC_RD;
            end
          end
        end
        S_AGE: begin
          if (sc == SC_END) begin
            sc <= '0;
            if (age_then_drop) begin
              age_then_drop <= 1'b0;
              after_drop    <= AD_RES;
              state         <= S_DROP;
            end else begin
              state <= S_RES;
            end
          end else begin
            sc <= sc + SCW'(1);
            if (s_head[sci] < SLOT_LIM && s_fl[sci] == 4'd0) begin
              if (s_age[sci] == 3'd0) begin
                cs    <= sci;
                cur   <= s_head[sci];
                ret   <= S_AGE;
                state <= S_FC_RD;
              end else begin
                s_age[sci] <= s_age[sci] - 3'd1;
              end
            end
          end
        end
        S_FC_RD: state <= S_FC_WR;
        S_FC_WR: begin
          free_head <= cur;
          if (rnext < SLOT_LIM) begin
            cur   <= rnext;
            state <= S_FC_RD;
          end else begin
            s_head[cs] <= cmr_pkg::SLOT_END;
            state      <= ret;
          end
        end
        S_RES: begin
          if (out_free) begin
            out_d <= '{status: st, src: 8'd0, pid: 16'd0, data: 64'd0, nb: 4'd0,
                       pos: 10'd0, last: 1'b1};
            state <= S_IDLE;
          end
        end
        S_R_SCAN: begin
          if (sc == SC_END) begin
            st    <= cmr_pkg::ST_NONE;
            state <= S_RES;
          end else begin
            sc <= sc + SCW'(1);
            if (s_head[sci] < SLOT_LIM && s_fl[sci] != 4'd0) begin
              cs  <= sci;
              cur <= s_head[sci];
              if (r_sz < 10'd2) begin
                ret   <= S_R_SCAN;
                state <= S_FC_RD;
              end else begin
                pos         <= 10'd2;
                words       <= '0;
                pend.status <= cmr_pkg::ST_DATA;
                pend.src    <= s_key[sci][23:16];
                pend.pid    <= s_key[sci][15:0];
                pend.data   <= '0;
                pend.nb     <= 4'd0;
                pend.pos    <= 10'd2;
                pend.last   <= 1'b0;
                state       <= S_RW_RD;
              end
            end
          end
        end
        S_RW_RD: state <= S_RW_CK;
        S_RW_CK: begin
          if (rnext < SLOT_LIM) begin
            if (pos_w > {1'b0, r_sz} || words >= cmr_pkg::READ_WORDS) begin
              state <= S_R_FIN;
            end else if (out_free) begin
              out_d     <= pend;
              pend.data <= rpay;
              pend.nb   <= 4'd8;
              pend.pos  <= pos_w[9:0];
              pos       <= pos_w[9:0];
              words     <= words + 6'd1;
              cur       <= rnext;
              state     <= S_RW_RD;
            end
          end else begin
            if (c_fl <= 4'd8 && pos_f <= {1'b0, r_sz} && words < cmr_pkg::READ_WORDS) begin
              if (out_free) begin
                out_d     <= pend;
                pend.data <= rpay & cmr_pkg::byte_mask(c_fl);
                pend.nb   <= c_fl;
                pend.pos  <= pos_f[9:0];
                state     <= S_R_FIN;
              end
            end else begin
              state <= S_R_FIN;
            end
          end
        end
        S_R_FIN: begin
          if (out_free) begin
            out_d <= '{status: pend.status, src: pend.src, pid: pend.pid, data: pend.data,
                       nb: pend.nb, pos: pend.pos, last: 1'b1};
            cur   <= s_head[cs];
            ret   <= S_IDLE;
            state <= S_FC_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = out_v;
  assign result.status      = out_d.status;
  assign result.source_out  = out_d.src;
  assign result.packet_out  = out_d.pid;
  assign result.data_word   = out_d.data;
  assign result.word_bytes  = out_d.nb;
  assign result.total_bytes = out_d.pos;
  assign result.last        = out_d.last;
endmodule

// ===== design/cmr_slot_mem.sv =====
// Slot link and payload memories, one write and one registered read per cycle.
module cmr_slot_mem #(
  parameter int SLOTS = 128
) (
  input  logic                clk,
  input  cmr_pkg::slot_wr_t   wr,
  input  logic [63:0]         wpay,
  input  cmr_pkg::slot_rd_t   rd,
  output cmr_pkg::slot_idx_t  rnext,
  output logic [63:0]         rpay
);
  localparam int IW = $clog2(SLOTS);

  cmr_pkg::slot_idx_t next_mem [SLOTS];
  logic [63:0]        pay_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      next_mem[wr.addr[IW-1:0]] <= wr.next;
      if (wr.pay_en) begin
        pay_mem[wr.addr[IW-1:0]] <= wpay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rnext <= next_mem[rd.addr[IW-1:0]];
      rpay  <= pay_mem[rd.addr[IW-1:0]];
    end
  end
endmodule

// ===== design/cmr_checker.sv =====
// Port-level checks of the reassembly pool, bound to the top level.
module cmr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  status,
  input logic [63:0] data_word,
  input logic [3:0]  word_bytes,
  input logic [9:0]  total_bytes,
  input logic        last
);
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_word)
      && $stable(total_bytes) && $stable(last))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during free list clearing");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cmr_pkg::ST_DATA |-> last && data_word == 64'd0
      && word_bytes == 4'd0 && total_bytes == 10'd0)
    else $error("status result carries payload");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cmr_pkg::ST_DATA && word_bytes == 4'd0 |-> total_bytes == 10'd2)
    else $error("packet header with wrong byte count");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cmr_pkg::ST_DATA |-> word_bytes <= 4'd8 && total_bytes >= 10'd2)
    else $error("data word out of range");
endmodule

bind can_multiframe_reassembly_pool_core cmr_checker u_cmr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .status      (result.status),
  .data_word   (result.data_word),
  .word_bytes  (result.word_bytes),
  .total_bytes (result.total_bytes),
  .last        (result.last)
);
